### src/bsfc_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bsfc_pkg: shared definitions of the binaural stereo FIR convolver
// Sizes, register codes and limits, payload structs and the command and status
// structs that join the controller and the datapath.
// -----------------------------------------------------------------------------
package bsfc_pkg;

   // Sizes of the filter and of the response store.
   localparam int TAPS           = 200;
   localparam int NUM_AZIMUTHS   = 25;
   localparam int NUM_ELEVATIONS = 50;
   localparam int SAMPLE_BITS    = 24;

   localparam int TAP_W      = $clog2(TAPS);
   localparam int HIST_AW    = $clog2(TAPS);
   localparam int COEF_DEPTH = NUM_AZIMUTHS * NUM_ELEVATIONS * TAPS;
   localparam int COEF_AW    = $clog2(COEF_DEPTH);
   localparam int PROD_BITS  = 2 * SAMPLE_BITS;
   localparam int ACC_BITS   = PROD_BITS + $clog2(TAPS) + 1;

   // Field widths of the input item.
   localparam int AZ_W  = 5;
   localparam int EL_W  = 6;
   localparam int LTAP_W = 8;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_AZIMUTH   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEVATION = 1'b1;

   // Register limits and reset values.
   localparam logic [AZ_W-1:0] AZ_LOW   = 5'd2;
   localparam logic [AZ_W-1:0] AZ_HIGH  = 5'd22;
   localparam logic [AZ_W-1:0] AZ_RESET = 5'd13;
   localparam logic [EL_W-1:0] EL_HIGH  = 6'd49;
   localparam logic [EL_W-1:0] EL_RESET = 6'd9;

   // Input item codes.
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_LOAD   = 1'b1;

   typedef struct packed {
      logic                          func;
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic [AZ_W-1:0]               load_azimuth;
      logic [EL_W-1:0]               load_elevation;
      logic [LTAP_W-1:0]             load_tap;
      logic                          load_channel;
      logic signed [SAMPLE_BITS-1:0] load_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load_we;   // write one coefficient from the request
      logic start;     // store the sample and prime the tap walk
      logic issue;     // read the next tap
      logic out_load;  // move the finished sums into the result register
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic pipe_busy; // a tap is still in the read or multiply stage
      logic rsp_free;  // the result register can take a new result
   } status_type;

endpackage
`default_nettype wire

### src/bsfc_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bsfc_ctrl: sequencer of the binaural stereo FIR convolver
// Accepts requests, counts the taps of one convolution and hands the finished
// result to the output register.
// -----------------------------------------------------------------------------
module bsfc_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_func,
   input  wire bsfc_pkg::status_type status,
   output bsfc_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   logic [bsfc_pkg::TAP_W-1:0]  tap_ff, tap_in;
   logic                        accept;

   // Requests are taken only between convolutions.
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == bsfc_pkg::FUNC_LOAD) begin
                  cmd.load_we = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  tap_in    = '0;
                  state_in  = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (tap_ff == bsfc_pkg::TAP_W'(bsfc_pkg::TAPS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy && status.rsp_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

endmodule
`default_nettype wire

### src/bsfc_datapath.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bsfc_datapath: storage and multiply-accumulate of the binaural convolver
// Holds the sample history, the response store for both ears, the selection
// registers, the shared two-ear MAC pipeline and the result register.
// -----------------------------------------------------------------------------
module bsfc_datapath (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire bsfc_pkg::req_type                    req_data,
   input  wire logic                                 csr_we,
   input  wire logic [bsfc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [bsfc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire bsfc_pkg::cmd_type                    cmd,
   output bsfc_pkg::status_type                      status,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output bsfc_pkg::rsp_type                         rsp_data
);

   localparam int SB  = bsfc_pkg::SAMPLE_BITS;
   localparam int AW  = bsfc_pkg::COEF_AW;
   localparam int HAW = bsfc_pkg::HIST_AW;
   localparam int PB  = bsfc_pkg::PROD_BITS;
   localparam int AB  = bsfc_pkg::ACC_BITS;
   localparam int QB  = AB - SB;

   // Memories.
   logic signed [SB-1:0] hist_mem   [bsfc_pkg::TAPS];
   logic signed [SB-1:0] coef_l_mem [bsfc_pkg::COEF_DEPTH];
   logic signed [SB-1:0] coef_r_mem [bsfc_pkg::COEF_DEPTH];
   logic [bsfc_pkg::TAPS-1:0] hist_vld_ff;

   // Selection registers and pointers.
   logic [bsfc_pkg::AZ_W-1:0] az_ff;
   logic [bsfc_pkg::EL_W-1:0] el_ff;
   logic [HAW-1:0]            wr_ptr_ff;
   logic [HAW-1:0]            rd_pos_ff;
   logic [AW-1:0]             coef_addr_ff;

   // Pipeline registers.
   logic                  rd_vld_ff, mul_vld_ff;
   logic signed [SB-1:0]  hist_rd_ff, coef_l_rd_ff, coef_r_rd_ff;
   logic                  hist_ok_ff;
   logic signed [PB-1:0]  prod_l_ff, prod_r_ff;
   logic signed [AB-1:0]  acc_l_ff, acc_r_ff;

   logic                  rsp_valid_ff;
   bsfc_pkg::rsp_type     rsp_data_ff;

   logic [AW-1:0]         load_addr;
   logic                  load_in_range;
   logic [AW-1:0]         sel_base;
   logic signed [SB-1:0]  mul_sample;
   logic signed [SB-1:0]  left_q, right_q;

   // Address of a loaded coefficient and its range check.
   assign load_addr = (AW'(req_data.load_azimuth) * AW'(bsfc_pkg::NUM_ELEVATIONS)
                       + AW'(req_data.load_elevation)) * AW'(bsfc_pkg::TAPS)
                      + AW'(req_data.load_tap);
   assign load_in_range =
      (32'(req_data.load_azimuth) < bsfc_pkg::NUM_AZIMUTHS) &&
      (32'(req_data.load_elevation) < bsfc_pkg::NUM_ELEVATIONS) &&
      (32'(req_data.load_tap) < bsfc_pkg::TAPS);

   // First tap of the selected response.
   assign sel_base = (AW'(az_ff) * AW'(bsfc_pkg::NUM_ELEVATIONS) + AW'(el_ff))
                     * AW'(bsfc_pkg::TAPS);

   // Configuration writes clamp into the legal ranges.
   always_ff @(posedge clock) begin
      if (reset) begin
         az_ff <= bsfc_pkg::AZ_RESET;
         el_ff <= bsfc_pkg::EL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            bsfc_pkg::CSR_AZIMUTH: begin
               if (csr_wdata < bsfc_pkg::CSR_DATA_W'(bsfc_pkg::AZ_LOW)) begin
                  az_ff <= bsfc_pkg::AZ_LOW;
               end else if (csr_wdata > bsfc_pkg::CSR_DATA_W'(bsfc_pkg::AZ_HIGH)) begin
                  az_ff <= bsfc_pkg::AZ_HIGH;
               end else begin
                  az_ff <= csr_wdata[bsfc_pkg::AZ_W-1:0];
               end
            end
            bsfc_pkg::CSR_ELEVATION: begin
               if (csr_wdata > bsfc_pkg::EL_HIGH) begin
                  el_ff <= bsfc_pkg::EL_HIGH;
               end else begin
                  el_ff <= csr_wdata;
               end
            end
            default: begin
               az_ff <= az_ff;
            end
         endcase
      end
   end

   // Response store for both ears: one write per load, one read per tap.
   always_ff @(posedge clock) begin
      if (cmd.load_we && load_in_range) begin
         if (req_data.load_channel) begin
            coef_r_mem[load_addr] <= req_data.load_value;
         end else begin
            coef_l_mem[load_addr] <= req_data.load_value;
         end
      end
      if (cmd.issue) begin
         coef_l_rd_ff <= coef_l_mem[coef_addr_ff];
         coef_r_rd_ff <= coef_r_mem[coef_addr_ff];
      end
   end

   // Sample history: the new sample is written when a convolution starts.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         hist_mem[wr_ptr_ff] <= req_data.sample_in;
      end
      if (cmd.issue) begin
         hist_rd_ff <= hist_mem[rd_pos_ff];
      end
   end

   // Valid bits stand for the cleared history after reset; pointers walk the ring.
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
         wr_ptr_ff   <= '0;
         hist_ok_ff  <= 1'b0;
      end else begin
         if (cmd.start) begin
            hist_vld_ff[wr_ptr_ff] <= 1'b1;
            if (wr_ptr_ff == HAW'(bsfc_pkg::TAPS - 1)) begin
               wr_ptr_ff <= '0;
            end else begin
               wr_ptr_ff <= wr_ptr_ff + 1'b1;
            end
         end
         if (cmd.issue) begin
            hist_ok_ff <= hist_vld_ff[rd_pos_ff];
         end
      end
   end

   // Read addresses: newest sample backward, coefficients forward.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rd_pos_ff    <= wr_ptr_ff;
         coef_addr_ff <= sel_base;
      end else if (cmd.issue) begin
         coef_addr_ff <= coef_addr_ff + 1'b1;
         if (rd_pos_ff == '0) begin
            rd_pos_ff <= HAW'(bsfc_pkg::TAPS - 1);
         end else begin
            rd_pos_ff <= rd_pos_ff - 1'b1;
         end
      end
   end

   // Pipeline occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= cmd.issue;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   // Multiply stage; a history slot never written counts as zero.
   assign mul_sample = hist_ok_ff ? hist_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         prod_l_ff <= PB'(mul_sample * coef_l_rd_ff);
         prod_r_ff <= PB'(mul_sample * coef_r_rd_ff);
      end
   end

   // Accumulate stage.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_l_ff <= '0;
         acc_r_ff <= '0;
      end else if (mul_vld_ff) begin
         acc_l_ff <= acc_l_ff + AB'(prod_l_ff);
         acc_r_ff <= acc_r_ff + AB'(prod_r_ff);
      end
   end

   // Scale by one half with round half up, then saturate to the sample width.
   function automatic logic signed [SB-1:0] finish(input logic signed [AB-1:0] acc);
      logic signed [AB-1:0] rounded;
      logic signed [QB-1:0] q;
      rounded = acc + (AB'(1) <<< (SB - 1));
      q       = QB'(rounded >>> SB);
      if (q > QB'(signed'({1'b0, {(SB-1){1'b1}}}))) begin
         finish = {1'b0, {(SB-1){1'b1}}};
      end else if (q < QB'(signed'({1'b1, {(SB-1){1'b0}}}))) begin
         finish = {1'b1, {(SB-1){1'b0}}};
      end else begin
         finish = q[SB-1:0];
      end
   endfunction

   assign left_q  = finish(acc_l_ff);
   assign right_q = finish(acc_r_ff);

   // Result register holds a result until the transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.left_out  <= left_q;
         rsp_data_ff.right_out <= right_q;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_data_ff;
   assign status.pipe_busy = rd_vld_ff || mul_vld_ff;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

endmodule
`default_nettype wire

### src/binaural_stereo_fir_convolver.sv
`default_nettype none
// An audio request (func 0) runs from its transfer until its left/right result is offered:
// one shared two-ear multiply-accumulate walks the taps one per cycle, reading the
// sample history and the response store through single-ported memories; then the
// read, multiply and accumulate stages drain, and the result is loaded once the result
// register is free. The next request is taken once the sequencer is idle again.
// A coefficient load (func 1) gives no result. New requests are stalled during a
// convolution; a finished result waits in its own register, so the next request can
// start while it is not yet taken. The response store has no reset: select only
// responses whose coefficients were all loaded. Sample history clears at reset
// through valid bits, with no clearing pass.
// -----------------------------------------------------------------------------
// binaural_stereo_fir_convolver: mono to binaural stereo FIR filter
// Convolves each mono sample with the selected head-related impulse response of
// each ear and scales by one half, with azimuth and elevation set by registers.
// -----------------------------------------------------------------------------
module binaural_stereo_fir_convolver (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire bsfc_pkg::req_type                  req_data,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output bsfc_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_we,
   input  wire logic [bsfc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bsfc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   bsfc_pkg::cmd_type    cmd;
   bsfc_pkg::status_type status;

   // Sequencer.
   bsfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_data.func),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage and arithmetic.
   bsfc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
